// ===== sv/two_button_debounce_chord_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the two-button debounce / chord block
// Shared property forms, clocked and disabled on the synchronous reset.
// ---------------------------------------------------------------------------
`ifndef TWO_BUTTON_DEBOUNCE_CHORD_DEFINES_SVH
`define TWO_BUTTON_DEBOUNCE_CHORD_DEFINES_SVH

// same-cycle implication
`define TBDC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbdc assertion failed");

// next-cycle implication
`define TBDC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbdc assertion failed");

`endif

// ===== sv/tbdc_pkg.sv =====
// ---------------------------------------------------------------------------
// tbdc_pkg
// Types and constants shared by the two-button debounce / chord block.
// ---------------------------------------------------------------------------
package tbdc_pkg;

   localparam int TICK_W     = 32;
   localparam int DEB_W      = 10;
   localparam int WIN_W      = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [DEB_W-1:0] DEBOUNCE_RST = DEB_W'(50);
   localparam logic [WIN_W-1:0] WINDOW_RST   = WIN_W'(150);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CHORD_WINDOW = CSR_IDX_W'(1);

   typedef struct packed {
      logic level_one;
      logic level_two;
      logic take_one;
      logic take_two;
      logic take_both;
      logic discard;
   } req_type;

   typedef struct packed {
      logic              event_one;
      logic              event_two;
      logic              event_both;
      logic              both_held;
      logic [TICK_W-1:0] both_held_ticks;
   } rsp_type;

   // per-button status after this tick's debounce
   typedef struct packed {
      logic stable;     // debounced level, 1 = pressed
      logic press_new;  // press accepted on this tick
   } btn_type;

endpackage

// ===== sv/tbdc_debounce.sv =====
// ---------------------------------------------------------------------------
// tbdc_debounce
// One-button debouncer: tracks raw level and its last change time, accepts a
// level once it has held for the programmed number of ticks.
// ---------------------------------------------------------------------------
module tbdc_debounce import tbdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [TICK_W-1:0] now,
   input  logic [DEB_W-1:0]  hold_ticks,
   input  logic              pressed_raw,
   output btn_type           status
);

   logic              raw_ff, raw_in;
   logic              stable_ff, stable_in;
   logic [TICK_W-1:0] last_ff, last_in;
   logic [TICK_W-1:0] age;
   logic              accept;

   always_comb begin
      raw_in  = pressed_raw;
      last_in = (pressed_raw != raw_ff) ? now : last_ff;
      age     = now - last_in;
      accept  = age >= TICK_W'(hold_ticks);
      stable_in = accept ? raw_in : stable_ff;
      status.stable    = stable_in;
      status.press_new = accept && raw_in && !stable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         stable_ff <= 1'b0;
         last_ff   <= '0;
      end else if (step) begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         last_ff   <= last_in;
      end
   end

endmodule

// ===== sv/tbdc_chord.sv =====
// ---------------------------------------------------------------------------
// tbdc_chord
// Pending presses, chord window resolution, event latches and both-held
// timing. Produces the result of the current tick.
// ---------------------------------------------------------------------------
`include "two_button_debounce_chord_defines.svh"

module tbdc_chord import tbdc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [TICK_W-1:0] now,
   input  logic [WIN_W-1:0]  chord_window_ms,
   input  btn_type           btn_one,
   input  btn_type           btn_two,
   input  req_type           req,
   output rsp_type           result
);

   logic [1:0]        pend_ff, pend_in;
   logic [TICK_W-1:0] ptime0_ff, ptime0_in;
   logic [TICK_W-1:0] ptime1_ff, ptime1_in;
   logic              held_ff, held_in;
   logic [TICK_W-1:0] since_ff, since_in;
   logic [2:0]        ev_ff, ev_in;

   logic [TICK_W-1:0] age0, age1, win;
   logic [1:0]        pend_a;
   logic [2:0]        ev_res;
   logic              both_now;

   always_comb begin
      win       = TICK_W'(chord_window_ms);
      pend_a    = pend_ff | {btn_two.press_new, btn_one.press_new};
      ptime0_in = btn_one.press_new ? now : ptime0_ff;
      ptime1_in = btn_two.press_new ? now : ptime1_ff;
      age0      = now - ptime0_in;
      age1      = now - ptime1_in;

      both_now = btn_one.stable && btn_two.stable;
      held_in  = both_now;
      since_in = both_now ? (held_ff ? since_ff : now) : '0;

      ev_res  = ev_ff;
      pend_in = pend_a;
      if (pend_a[0] && pend_a[1]) begin
         ev_res[2] = 1'b1;
         pend_in   = 2'b00;
      end else if (pend_a[0] && btn_two.stable && age1 < win) begin
         ev_res[2]  = 1'b1;
         pend_in[0] = 1'b0;
      end else if (pend_a[1] && btn_one.stable && age0 < win) begin
         ev_res[2]  = 1'b1;
         pend_in[1] = 1'b0;
      end else begin
         if (pend_a[0] && age0 > win) begin
            ev_res[0]  = 1'b1;
            pend_in[0] = 1'b0;
         end
         if (pend_a[1] && age1 > win) begin
            ev_res[1]  = 1'b1;
            pend_in[1] = 1'b0;
         end
      end

      result.event_one       = ev_res[0];
      result.event_two       = ev_res[1];
      result.event_both      = ev_res[2];
      result.both_held       = both_now;
      result.both_held_ticks = both_now ? now - since_in : '0;

      // takes and discard act after reporting
      ev_in = ev_res & ~{req.take_both, req.take_two, req.take_one};
      if (req.discard) begin
         ev_in   = 3'b000;
         pend_in = 2'b00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 2'b00;
         ptime0_ff <= '0;
         ptime1_ff <= '0;
         held_ff   <= 1'b0;
         since_ff  <= '0;
         ev_ff     <= 3'b000;
      end else if (step) begin
         pend_ff   <= pend_in;
         ptime0_ff <= ptime0_in;
         ptime1_ff <= ptime1_in;
         held_ff   <= held_in;
         since_ff  <= since_in;
         ev_ff     <= ev_in;
      end
   end

   `TBDC_ASSERT_NXT(a_discard_clears, clock, reset, step && req.discard,
                    pend_ff == 2'b00 && ev_ff == 3'b000)
   `TBDC_ASSERT_IMP(a_held_since_zero, clock, reset, !held_ff, since_ff == '0)

endmodule

// ===== sv/two_button_debounce_chord.sv =====
// ---------------------------------------------------------------------------
// two_button_debounce_chord
// Two-button debouncer with chord detection, one tick request per cycle while rsp is not stalled.
//
//   channel   ports                          role
//   req       req_valid/req_ready/req_data   one tick: raw levels, takes
//   rsp       rsp_valid/rsp_ready/rsp_data   event latches, both-held time
//   csr       csr_we/csr_index/csr_wdata     debounce and window registers
//
// A request is captured in an input register; once the output register is
// free or drained by rsp_ready, the debounce and chord logic runs and the
// result lands in the output register, which raises rsp_valid; one request
// is taken every cycle while rsp_ready stays high.
// Each tick's state update completes within its step, which sets the rate.
// Reset is synchronous; config registers return to 50 and 150.
// A stalled result holds its register; the input register still takes one
// more request before req_ready drops.
// ---------------------------------------------------------------------------
`include "two_button_debounce_chord_defines.svh"

module two_button_debounce_chord import tbdc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DEB_W-1:0]  debounce_ff;
   logic [WIN_W-1:0]  window_ff;
   logic              in_vld_ff, in_vld_in;
   req_type           req_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_type           rsp_ff;
   logic [TICK_W-1:0] now_ff, now_in;
   logic              advance, step;
   btn_type           btn_one, btn_two;
   rsp_type           result;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RST;
         window_ff   <= WINDOW_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS:  debounce_ff <= csr_wdata[DEB_W-1:0];
            CSR_CHORD_WINDOW: window_ff   <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_vld_ff || rsp_ready;
   assign step      = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;
   assign now_in    = now_ff + TICK_W'(1);

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (step) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         now_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (step) begin
            now_ff <= now_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   tbdc_debounce u_deb_one (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .now         (now_in),
      .hold_ticks  (debounce_ff),
      .pressed_raw (!req_ff.level_one),
      .status      (btn_one)
   );

   tbdc_debounce u_deb_two (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .now         (now_in),
      .hold_ticks  (debounce_ff),
      .pressed_raw (!req_ff.level_two),
      .status      (btn_two)
   );

   tbdc_chord u_chord (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .now             (now_in),
      .chord_window_ms (window_ff),
      .btn_one         (btn_one),
      .btn_two         (btn_two),
      .req             (req_ff),
      .result          (result)
   );

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `TBDC_ASSERT_NXT(a_step_gives_rsp, clock, reset, step, rsp_vld_ff)
   `TBDC_ASSERT_IMP(a_stall_cause, clock, reset, !req_ready,
                    in_vld_ff && rsp_vld_ff && !rsp_ready)
   `TBDC_ASSERT_IMP(a_ticks_need_held, clock, reset,
                    rsp_vld_ff && !rsp_ff.both_held, rsp_ff.both_held_ticks == '0)

endmodule
